// ===== rtl/core/kcd_pkg.sv =====
// Shared types and constants for the key click / long-press detector.
// No dependencies; imported by every module of the block.
package kcd_pkg;

	localparam int NUM_KEYS  = 8;
	localparam int COUNT_MAX = 65535;
	localparam int MAX_HITS  = 14;
	localparam int KEY_W     = 3;
	localparam int TICK_W    = 16;

	localparam logic [3:0] CLK_NONE = 4'd0;
	localparam logic [3:0] CLK_ONE  = 4'd1;
	localparam logic [3:0] CLK_TWO  = 4'd2;
	localparam logic [3:0] CLK_ERR  = 4'd15;

	typedef enum logic [1:0] {
		PH_REL     = 2'd0,
		PH_PCHK    = 2'd1,
		PH_PRESSED = 2'd2,
		PH_RCHK    = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		EV_PRESS     = 3'd0,
		EV_RELEASE   = 3'd1,
		EV_SHORT_UP  = 3'd2,
		EV_LONG      = 3'd3,
		EV_LONG_HOLD = 3'd4,
		EV_LONG_LONG = 3'd5,
		EV_LONG_UP   = 3'd6,
		EV_MULTI     = 3'd7
	} ev_code_t;

	typedef enum logic [2:0] {
		REG_DEBOUNCE  = 3'd0,
		REG_LONG      = 3'd1,
		REG_LONG_LONG = 3'd2,
		REG_HOLD      = 3'd3,
		REG_WINDOW    = 3'd4,
		REG_MAX_HITS  = 3'd5,
		REG_EV_ENABLE = 3'd6
	} reg_idx_t;

	typedef struct packed {
		phase_t            phase;
		logic              active;
		logic [TICK_W-1:0] ticks;
		logic [3:0]        click;
		logic              long_mark;
		logic              level;
	} key_state_t;

	typedef struct packed {
		logic [7:0]        debounce;
		logic [TICK_W-1:0] long_t;
		logic [TICK_W-1:0] long_long_t;
		logic [TICK_W-1:0] hold;
		logic [TICK_W-1:0] window;
		logic [31:0]       max_hits;
		logic [7:0]        ev_enable;
	} cfg_t;

	typedef struct packed {
		ev_code_t   code;
		logic [3:0] hits;
	} ev_t;

	// evaluation result for the key at the head of the ring
	typedef struct packed {
		key_state_t nxt;
		logic [1:0] n_ev;
		ev_t        ev0;
		ev_t        ev1;
		logic       need_mod;
	} eval_t;

endpackage

// ===== rtl/core/key_click_long_press_detector_core.sv =====
// Key click / long-press detector, top level.
// Depends on kcd_pkg, kcd_cell, kcd_rem, kcd_eval.
//
// Slave stream: one transaction per scan tick, tdata[7:0] = key levels (bit k = key k).
// Master stream: one transaction per event, keys in ascending order; tlast marks the
// final event of a tick. A tick with no events produces no output.
// Config channel: cfg_index selects a register (0 debounce, 1 long, 2 long-long,
// 3 hold period, 4 click window, 5 packed max hits, 6 event enable); always ready.
// Write it only while the block is idle.
// Key state sits in a ring of NUM_KEYS cells that rotates one key per step; the key
// at the head is evaluated and written back at the tail.
// Per tick the ring steps once per key once its events are pushed; a key whose long-hold
// period check needs it first runs the serial remainder unit; a flush state ends the tick.
// The input is taken again once the tick's last event has been handed to the output
// register. When the receiver stalls, the event pipeline (one pending event plus the
// output register) fills and the ring stops stepping until the stall clears.
// Reset puts every key released and inactive and loads the register defaults.
module key_click_long_press_detector_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] key_levels
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [2:0] key_index, [5:3] event_code, [9:6] hit_count
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import kcd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_EVAL  = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

	state_t            state_q;
	cfg_t              cfg_q;
	logic [KEY_W-1:0]  key_q;
	logic [1:0]        sub_q;
	logic              pend_v_q, out_v_q, out_last_q;
	ev_t               pend_q, out_ev_q;
	logic [KEY_W-1:0]  pend_key_q, out_key_q;

	key_state_t        cell_q [NUM_KEYS];
	key_state_t        cell_d [NUM_KEYS];
	eval_t             ev_res;
	logic              in_acc, shift_en, mod_ok, rem_start, rem_busy, rem_done, rem_zero;
	logic              out_free, push, key_fin, out_load;
	ev_t               cur_ev;
	logic [TICK_W-1:0] heff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{debounce: 8'd2, long_t: 16'd100, long_long_t: 16'd300,
				hold: 16'd10, window: 16'd30, max_hits: 32'h1111_1111, ev_enable: 8'hFF};
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_DEBOUNCE:  cfg_q.debounce    <= cfg_data[7:0];
				REG_LONG:      cfg_q.long_t      <= cfg_data[TICK_W-1:0];
				REG_LONG_LONG: cfg_q.long_long_t <= cfg_data[TICK_W-1:0];
				REG_HOLD:      cfg_q.hold        <= cfg_data[TICK_W-1:0];
				REG_WINDOW:    cfg_q.window      <= cfg_data[TICK_W-1:0];
				REG_MAX_HITS:  cfg_q.max_hits    <= cfg_data;
				REG_EV_ENABLE: cfg_q.ev_enable   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign in_acc = s_axis_tvalid && s_axis_tready;

	genvar g;
	generate
		for (g = 0; g < NUM_KEYS; g++) begin : g_ring
			if (g == NUM_KEYS - 1) begin : g_tail
				assign cell_d[g] = ev_res.nxt;
			end else begin : g_mid
				assign cell_d[g] = cell_q[g+1];
			end
			kcd_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (shift_en),
				.load_en  (in_acc),
				.level_in (s_axis_tdata[g]),
				.d        (cell_d[g]),
				.q        (cell_q[g])
			);
		end
	endgenerate

	kcd_eval u_eval (
		.cur      (cell_q[0]),
		.cfg      (cfg_q),
		.key      (key_q),
		.mod_zero (rem_zero),
		.res      (ev_res)
	);

	assign heff = (cfg_q.hold == '0) ? TICK_W'(1) : cfg_q.hold;

	kcd_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rem_start),
		.clear  (shift_en),
		.x      (cell_q[0].ticks - cfg_q.long_t),
		.h      (heff),
		.busy   (rem_busy),
		.done   (rem_done),
		.zero   (rem_zero)
	);

	assign mod_ok    = !ev_res.need_mod || rem_done;
	assign rem_start = (state_q == S_EVAL) && ev_res.need_mod && !rem_done && !rem_busy;
	assign out_free  = !out_v_q || m_axis_tready;
	assign cur_ev    = (sub_q == 2'd0) ? ev_res.ev0 : ev_res.ev1;
	assign push      = (state_q == S_EVAL) && mod_ok && (sub_q < ev_res.n_ev) &&
		(!pend_v_q || out_free);
	assign key_fin   = (state_q == S_EVAL) && mod_ok && (sub_q >= ev_res.n_ev);
	assign shift_en  = key_fin;
	// output register takes the pending event on a push behind it or at the flush
	assign out_load  = (push && pend_v_q) || (state_q == S_FLUSH && pend_v_q && out_free);

	assign s_axis_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			key_q    <= '0;
			sub_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_load) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (push) begin
						sub_q    <= sub_q + 2'd1;
						pend_v_q <= 1'b1;
					end
					if (key_fin) begin
						sub_q <= '0;
						key_q <= (key_q == KEY_W'(NUM_KEYS - 1)) ? '0 : key_q + 1'b1;
						if (key_q == KEY_W'(NUM_KEYS - 1)) state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			pend_q     <= cur_ev;
			pend_key_q <= key_q;
			if (pend_v_q) begin
				out_ev_q   <= pend_q;
				out_key_q  <= pend_key_q;
				out_last_q <= 1'b0;
			end
		end else if (state_q == S_FLUSH && pend_v_q && out_free) begin
			out_ev_q   <= pend_q;
			out_key_q  <= pend_key_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {6'd0, out_ev_q.hits, out_ev_q.code, out_key_q};

	// a tick always ends with the pending event drained
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_v_q)
		else $error("pending event left over at end of tick");

	a_idle_key0: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> key_q == '0)
		else $error("key counter not rewound");

	a_rem_start: assert property (@(posedge clk) disable iff (!arst_n)
		rem_start |=> rem_busy)
		else $error("remainder unit did not start");

	a_no_shift_while_rem: assert property (@(posedge clk) disable iff (!arst_n)
		rem_busy |-> !shift_en)
		else $error("ring stepped during remainder check");
endmodule

// ===== rtl/core/kcd_cell.sv =====
// One key cell of the state ring: holds a key's state and passes it to its neighbor.
// Depends on kcd_pkg.
module kcd_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift_en,
	input  logic                load_en,
	input  logic                level_in,
	input  kcd_pkg::key_state_t d,
	output kcd_pkg::key_state_t q
);
	import kcd_pkg::*;

	key_state_t st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_REL, active: 1'b0, ticks: '0, click: CLK_NONE,
				long_mark: 1'b0, level: 1'b0};
		end else if (load_en) begin
			st_q.level <= level_in;
		end else if (shift_en) begin
			st_q <= d;
		end
	end

	assign q = st_q;
endmodule

// ===== rtl/core/kcd_rem.sv =====
// Iterative remainder test (x mod h == 0), one quotient bit per cycle.
// Depends on kcd_pkg.
module kcd_rem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      clear,
	input  logic [kcd_pkg::TICK_W-1:0] x,
	input  logic [kcd_pkg::TICK_W-1:0] h,
	output logic                      busy,
	output logic                      done,
	output logic                      zero
);
	import kcd_pkg::*;

	localparam int CNT_W = $clog2(TICK_W + 1);

	logic [TICK_W-1:0] r_q, x_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [TICK_W:0]   rs;

	always_comb begin
		rs = {r_q, x_q[TICK_W-1]};
		if (rs >= {1'b0, h}) rs = rs - {1'b0, h};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(TICK_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) done_q <= 1'b1;
		end else if (clear) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			x_q <= x;
		end else if (cnt_q != '0) begin
			r_q <= rs[TICK_W-1:0];
			x_q <= {x_q[TICK_W-2:0], 1'b0};
		end
	end

	assign busy = (cnt_q != '0);
	assign done = done_q;
	assign zero = (r_q == '0);
endmodule

// ===== rtl/core/kcd_eval.sv =====
// Next-state and event logic for the key at the head of the ring.
// Depends on kcd_pkg.
module kcd_eval (
	input  kcd_pkg::key_state_t      cur,
	input  kcd_pkg::cfg_t            cfg,
	input  logic [kcd_pkg::KEY_W-1:0] key,
	input  logic                     mod_zero,
	output kcd_pkg::eval_t           res
);
	import kcd_pkg::*;

	key_state_t        s;
	logic [3:0]        mh_raw, mh;
	logic [TICK_W-1:0] heff, lim;
	logic [TICK_W:0]   t1;
	logic              sc, do_hold, do_rhold, do_rproc, do_press, skip_clr;
	logic              r0v, r1v, en0, en1;
	ev_t               r0, r1;

	always_comb begin
		s        = cur;
		heff     = (cfg.hold == '0) ? TICK_W'(1) : cfg.hold;
		mh_raw   = cfg.max_hits[{key, 2'b00} +: 4];
		mh       = (mh_raw == 4'd0) ? 4'd1 :
			(mh_raw > 4'(MAX_HITS)) ? 4'(MAX_HITS) : mh_raw;
		sc       = !cur.long_mark && (cur.click != CLK_NONE);
		do_hold  = 1'b0;
		do_rhold = 1'b0;
		do_rproc = 1'b0;
		do_press = 1'b0;
		skip_clr = 1'b0;
		r0v      = 1'b0;
		r1v      = 1'b0;
		r0       = '{code: EV_PRESS, hits: 4'd0};
		r1       = '{code: EV_PRESS, hits: 4'd0};

		case (cur.phase)
			PH_REL: begin
				if (cur.level) begin
					s.phase = PH_PCHK;
					if (!cur.active) begin
						s.active = 1'b1;
						s.ticks  = '0;
					end
				end else if (cur.active) begin
					do_rhold = 1'b1;
				end
			end
			PH_PRESSED: begin
				if (cur.active) begin
					if (!cur.level) s.phase = PH_RCHK;
					else do_hold = 1'b1;
				end
			end
			PH_RCHK: begin
				if (cur.active) begin
					if (!cur.level) begin
						s.phase  = PH_REL;
						s.ticks  = '0;
						do_rproc = 1'b1;
					end else begin
						s.phase = PH_PRESSED;
						do_hold = 1'b1;
					end
				end
			end
			default: begin
				if (cur.active) begin
					if (cur.level) begin
						if (cur.ticks >= {8'd0, cfg.debounce}) begin
							s.phase  = PH_PRESSED;
							s.ticks  = '0;
							do_press = 1'b1;
						end
					end else begin
						s.phase  = PH_REL;
						do_rhold = 1'b1;
					end
				end
			end
		endcase

		if (do_rhold) begin
			if (mh > 4'd1 && sc) begin
				if (cur.ticks < cfg.window) begin
					skip_clr = 1'b1;
				end else if (cur.click == CLK_ONE) begin
					r0v = 1'b1;
					r0  = '{code: EV_SHORT_UP, hits: 4'd0};
				end else if (cur.click != CLK_ERR) begin
					r0v = 1'b1;
					r0  = '{code: EV_MULTI, hits: cur.click};
				end
			end
			if (!skip_clr) begin
				s.active    = 1'b0;
				s.ticks     = '0;
				s.click     = CLK_NONE;
				s.long_mark = 1'b0;
			end
		end

		if (do_rproc) begin
			r0v = 1'b1;
			r0  = '{code: EV_RELEASE, hits: 4'd0};
			if (sc) begin
				if (mh == 4'd1) begin
					r1v = 1'b1;
					r1  = '{code: EV_SHORT_UP, hits: 4'd0};
				end
			end else if (cur.long_mark) begin
				r1v = 1'b1;
				r1  = '{code: EV_LONG_UP, hits: 4'd0};
			end
		end

		if (do_hold) begin
			if (cur.ticks > cfg.long_t) begin
				if (cur.ticks == cfg.long_long_t) begin
					s.long_mark = 1'b1;
					s.click     = CLK_NONE;
					r0v         = 1'b1;
					r0          = '{code: EV_LONG_LONG, hits: 4'd0};
				end else if (mod_zero) begin
					r0v = 1'b1;
					r0  = '{code: EV_LONG_HOLD, hits: 4'd0};
				end
			end else if (cur.ticks == cfg.long_t) begin
				s.long_mark = 1'b1;
				s.click     = CLK_NONE;
				r0v         = 1'b1;
				r0          = '{code: EV_LONG, hits: 4'd0};
			end
		end

		if (do_press) begin
			r0v = 1'b1;
			r0  = '{code: EV_PRESS, hits: 4'd0};
			if (!cur.long_mark && cur.click == CLK_NONE) begin
				s.click = CLK_ONE;
			end else if (!(mh <= 4'd1 || cur.long_mark)) begin
				if (cur.click == CLK_ONE) s.click = CLK_TWO;
				else if (cur.click != CLK_ERR) begin
					if (mh > cur.click) s.click = cur.click + 4'd1;
					else s.click = CLK_ERR;
				end
			end
		end

		// tick counter, folded back by one hold period near the top
		lim = TICK_W'(COUNT_MAX) - heff;
		t1  = {1'b0, s.ticks} + 1'b1;
		if (t1 > {1'b0, lim}) t1 = (t1 >= {1'b0, heff}) ? t1 - {1'b0, heff} : '0;
		if (s.active) s.ticks = t1[TICK_W-1:0];

		en0 = r0v && cfg.ev_enable[r0.code];
		en1 = r1v && cfg.ev_enable[r1.code];

		res.nxt      = s;
		res.n_ev     = {1'b0, en0} + {1'b0, en1};
		res.ev0      = en0 ? r0 : r1;
		res.ev1      = r1;
		res.need_mod = do_hold && (cur.ticks > cfg.long_t) &&
			(cur.ticks != cfg.long_long_t);
	end
endmodule

// ===== tb/kcd_checker.sv =====
// Scoreboard for the key click / long-press detector: predicts events per scan tick.
// Depends on kcd_pkg; watches the scan, event and register channels of the core.
module kcd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          events_seen
);
	import kcd_pkg::*;

	typedef struct packed {
		logic [2:0] key;
		ev_code_t   code;
		logic [3:0] hits;
		logic       last;
	} key_event_t;

	key_event_t  event_q[$];
	int          tick_events;

	logic [7:0]  debounce_r;
	int unsigned long_r, long_long_r, hold_r, window_r;
	logic [31:0] max_hits_r;
	logic [7:0]  enable_r;

	phase_t      phase[8];
	logic        active[8];
	int unsigned ticks[8];
	logic [3:0]  click[8];
	logic        long_mark[8];

	assign pending = event_q.size();

	function automatic int unsigned hold_eff();
		return (hold_r == 0) ? 1 : hold_r;
	endfunction

	function automatic int unsigned max_hit_of(int k);
		int unsigned m;
		m = (max_hits_r >> (4 * k)) & 4'hf;
		if (m == 0) m = 1;
		if (m > MAX_HITS) m = MAX_HITS;
		return m;
	endfunction

	function automatic logic short_class(int k);
		return !long_mark[k] && click[k] != CLK_NONE;
	endfunction

	task push_event(int k, ev_code_t code, logic [3:0] hits);
		key_event_t e;
		if (!enable_r[code] || tick_events >= 16) return;
		e.key  = k[2:0];
		e.code = code;
		e.hits = hits;
		e.last = 1'b0;
		event_q.push_back(e);
		tick_events++;
	endtask

	task release_hold(int k);
		if (max_hit_of(k) > 1 && short_class(k)) begin
			if (ticks[k] < window_r) return;
			if (click[k] == CLK_ONE) push_event(k, EV_SHORT_UP, 4'd0);
			else if (click[k] != CLK_ERR) push_event(k, EV_MULTI, click[k]);
		end
		active[k]    = 1'b0;
		ticks[k]     = 0;
		click[k]     = CLK_NONE;
		long_mark[k] = 1'b0;
	endtask

	task release_proc(int k);
		push_event(k, EV_RELEASE, 4'd0);
		if (short_class(k)) begin
			if (max_hit_of(k) == 1) push_event(k, EV_SHORT_UP, 4'd0);
		end else if (long_mark[k]) begin
			push_event(k, EV_LONG_UP, 4'd0);
		end
	endtask

	task press_hold(int k);
		int unsigned t;
		t = ticks[k];
		if (t > long_r) begin
			if (t == long_long_r) begin
				long_mark[k] = 1'b1;
				click[k]     = CLK_NONE;
				push_event(k, EV_LONG_LONG, 4'd0);
			end else if (((t - long_r) % hold_eff()) == 0) begin
				push_event(k, EV_LONG_HOLD, 4'd0);
			end
		end else if (t == long_r) begin
			long_mark[k] = 1'b1;
			click[k]     = CLK_NONE;
			push_event(k, EV_LONG, 4'd0);
		end
	endtask

	task press_proc(int k);
		int unsigned mh;
		mh = max_hit_of(k);
		push_event(k, EV_PRESS, 4'd0);
		if (!long_mark[k] && click[k] == CLK_NONE) begin
			click[k] = CLK_ONE;
			return;
		end
		if (mh <= 1 || long_mark[k]) return;
		if (click[k] == CLK_ONE) click[k] = CLK_TWO;
		else if (click[k] != CLK_ERR) begin
			if (mh > click[k]) click[k] = click[k] + 4'd1;
			else click[k] = CLK_ERR;
		end
	endtask

	// one scan tick: every key in ascending order, then mark the final event
	task predict_tick(logic [7:0] levels);
		int unsigned h, lim, t;
		logic pr;
		tick_events = 0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			pr = levels[k];
			case (phase[k])
				PH_REL: begin
					if (pr) begin
						phase[k] = PH_PCHK;
						if (!active[k]) begin
							active[k] = 1'b1;
							ticks[k]  = 0;
						end
					end else if (active[k]) begin
						release_hold(k);
					end
				end
				PH_PRESSED: begin
					if (active[k]) begin
						if (!pr) phase[k] = PH_RCHK;
						else press_hold(k);
					end
				end
				PH_RCHK: begin
					if (active[k]) begin
						if (!pr) begin
							phase[k] = PH_REL;
							ticks[k] = 0;
							release_proc(k);
						end else begin
							phase[k] = PH_PRESSED;
							press_hold(k);
						end
					end
				end
				default: begin
					if (active[k]) begin
						if (pr) begin
							if (ticks[k] >= debounce_r) begin
								phase[k] = PH_PRESSED;
								ticks[k] = 0;
								press_proc(k);
							end
						end else begin
							phase[k] = PH_REL;
							release_hold(k);
						end
					end
				end
			endcase
			if (active[k]) begin
				// counter drops back by one hold period before it can overflow
				h   = hold_eff();
				lim = (h <= COUNT_MAX) ? COUNT_MAX - h : 0;
				t   = ticks[k] + 1;
				if (t > lim) t = (t >= h) ? t - h : 0;
				ticks[k] = t & 16'hffff;
			end
		end
		if (tick_events > 0) event_q[event_q.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		key_event_t exp_ev;
		int         errs;
		errs = 0;
		if (!arst_n) begin
			event_q.delete();
			fail_count  <= 0;
			events_seen <= 0;
			debounce_r  = 8'd2;
			long_r      = 100;
			long_long_r = 300;
			hold_r      = 10;
			window_r    = 30;
			max_hits_r  = 32'h1111_1111;
			enable_r    = 8'hff;
			for (int k = 0; k < 8; k++) begin
				phase[k]     = PH_REL;
				active[k]    = 1'b0;
				ticks[k]     = 0;
				click[k]     = CLK_NONE;
				long_mark[k] = 1'b0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_DEBOUNCE:  debounce_r  = cfg_data[7:0];
					REG_LONG:      long_r      = cfg_data[15:0];
					REG_LONG_LONG: long_long_r = cfg_data[15:0];
					REG_HOLD:      hold_r      = cfg_data[15:0];
					REG_WINDOW:    window_r    = cfg_data[15:0];
					REG_MAX_HITS:  max_hits_r  = cfg_data;
					REG_EV_ENABLE: enable_r    = cfg_data[7:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) predict_tick(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				events_seen <= events_seen + 1;
				if (event_q.size() == 0) begin
					$error("unexpected event transaction: tdata=%h tlast=%b",
						m_axis_tdata, m_axis_tlast);
					errs++;
				end else begin
					exp_ev = event_q.pop_front();
					if (m_axis_tdata[2:0] !== exp_ev.key) begin
						$error("key_index: expected %0d, actual %0d", exp_ev.key,
							m_axis_tdata[2:0]);
						errs++;
					end
					if (m_axis_tdata[5:3] !== exp_ev.code) begin
						$error("event_code: expected %0d, actual %0d", exp_ev.code,
							m_axis_tdata[5:3]);
						errs++;
					end
					if (m_axis_tdata[9:6] !== exp_ev.hits) begin
						$error("hit_count: expected %0d, actual %0d", exp_ev.hits,
							m_axis_tdata[9:6]);
						errs++;
					end
					if (m_axis_tlast !== exp_ev.last) begin
						$error("last: expected %0d, actual %0d", exp_ev.last,
							m_axis_tlast);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
	end

endmodule

// ===== tb/tb.sv =====
// Top of the detector testbench: clock, reset, scan-tick stimulus, register phases.
// Depends on kcd_pkg, key_click_long_press_detector_core and kcd_checker.
module tb;
	import kcd_pkg::*;

	localparam int LIMIT      = 1000000;
	localparam int DRAIN      = 200;
	localparam int PER_PHASE  = 96;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid, s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid, m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	int          fail_count, pending, events_seen;
	int          cycles;
	int          ticks_sent;
	int          tx_idle_pct, rx_idle_pct;
	logic        stall_req, stall_done;
	int          stall_cnt;
	logic [7:0]  cur_levels;
	int          run_left[8];

	key_click_long_press_detector_core u_dut (.*);

	kcd_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// receiver: random back-pressure plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_cnt     <= 0;
			stall_done    <= 1'b0;
		end else if (stall_req && !stall_done) begin
			stall_cnt     <= 400;
			stall_done    <= 1'b1;
			m_axis_tready <= 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt     <= stall_cnt - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task send_tick(logic [7:0] levels);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= levels;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		ticks_sent++;
	endtask

	task write_regs(logic [7:0] deb, logic [15:0] lng, logic [15:0] llng,
			logic [15:0] hold, logic [15:0] win, logic [31:0] hits, logic [7:0] en);
		logic [31:0] vals[7];
		vals = '{deb, lng, llng, hold, win, hits, en};
		for (int i = 0; i < 7; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= i[2:0];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// wait until every event is out, then let a quiet tick finish inside the core
	task drain();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// key levels held for random runs so presses, clicks and long holds all occur;
	// about one tick in ten is raw noise
	task random_ticks(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) begin
				send_tick($urandom_range(255));
			end else begin
				for (int k = 0; k < 8; k++) begin
					if (run_left[k] == 0) begin
						cur_levels[k] = ~cur_levels[k];
						run_left[k] = ($urandom_range(3) == 0) ? $urandom_range(10, 30)
							: $urandom_range(1, 6);
					end
					run_left[k]--;
				end
				send_tick(cur_levels);
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		ticks_sent    = 0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'd0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_DEBOUNCE;
		cfg_data      = 32'd0;
		stall_req     = 1'b0;
		tx_idle_pct   = 0;
		rx_idle_pct   = 0;
		cur_levels    = 8'd0;
		for (int k = 0; k < 8; k++) run_left[k] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fast thresholds so every event code shows up in a few ticks
		write_regs(8'd0, 16'd3, 16'd6, 16'd1, 16'd2, 32'hF0E3_2510, 8'hff);
		for (int i = 0; i < 10; i++) send_tick(8'hff);
		send_tick(8'h00);
		send_tick(8'h00);
		for (int i = 0; i < 3; i++) begin
			send_tick(8'h55);
			send_tick(8'h55);
			send_tick(8'hAA);
			send_tick(8'h00);
		end
		for (int i = 0; i < 4; i++) send_tick(8'h00);
		drain();

		tx_idle_pct = 28;
		rx_idle_pct = 58;
		write_regs(8'd1, 16'd6, 16'd15, 16'd2, 16'd4, 32'h2345_6E32, 8'hff);
		stall_req <= 1'b1;
		random_ticks(PER_PHASE);
		drain();

		// hold period at its maximum makes the counter wrap on every tick
		tx_idle_pct = 58;
		rx_idle_pct = 28;
		write_regs(8'd0, 16'd1, 16'hffff, 16'hffff, 16'd1, 32'hFFFF_FFFF, 8'b1011_0101);
		random_ticks(PER_PHASE);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_regs(8'd2, 16'd10, 16'd25, 16'd0, 16'd8, 32'h0000_0000, 8'hff);
		random_ticks(PER_PHASE);
		drain();

		// slowest thresholds and every event masked
		write_regs(8'hff, 16'hffff, 16'hffff, 16'd5, 16'hffff, 32'h1234_5678, 8'h00);
		random_ticks(12);
		drain();

		$display("tb: %0d scan ticks over five register settings, %0d events checked",
			ticks_sent, events_seen);
		$display("tb: back-pressure phases plus one 400-cycle receiver hold-off");
		if (fail_count == 0 && pending == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== key_click_long_press_detector_core.f =====
rtl/core/kcd_pkg.sv
rtl/core/kcd_cell.sv
rtl/core/kcd_rem.sv
rtl/core/kcd_eval.sv
rtl/core/key_click_long_press_detector_core.sv
tb/kcd_checker.sv
tb/tb.sv
